/* rtl/lrupr_pkg.sv */
// lrupr_pkg: shared constants, item types and controller types for the
// LRU page replacement block. No dependencies.
package lrupr_pkg;

   localparam int FRAMES     = 16;
   localparam int PAGE_BITS  = 16;
   localparam int IDX_BITS   = $clog2(FRAMES);
   localparam int RANK_BITS  = IDX_BITS;
   localparam int CNT_BITS   = 16;
   localparam int CFG_BITS   = 5;
   localparam int GRP_SIZE   = 4;
   localparam int NUM_GRPS   = (FRAMES + GRP_SIZE - 1) / GRP_SIZE;

   localparam logic [CFG_BITS-1:0]  CFG_RESET = CFG_BITS'(16);
   localparam logic [RANK_BITS-1:0] RANK_MAX  = RANK_BITS'(FRAMES - 1);
   localparam logic [CNT_BITS-1:0]  COUNT_MAX = '1;

   typedef struct packed {
      logic [PAGE_BITS-1:0] page;
      logic                 last_ref;
   } req_type;

   typedef struct packed {
      logic                 fault;
      logic [IDX_BITS-1:0]  slot;
      logic                 evicted_valid;
      logic [PAGE_BITS-1:0] evicted_page;
      logic [CNT_BITS-1:0]  fault_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_SEL,
      ST_UPD
   } state_type;

   // controller -> datapath step commands
   typedef struct packed {
      logic load;
      logic cmp;
      logic sel;
      logic upd;
   } ctrl_cmd_type;

endpackage

/* rtl/lrupr_ctrl.sv */
// lrupr_ctrl: sequencer for one reference (lookup, select, update).
// Depends on lrupr_pkg.
module lrupr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   output lrupr_pkg::ctrl_cmd_type cmd
);

   lrupr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrupr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      case (state_ff)
         lrupr_pkg::ST_IDLE: begin
            state_in = start ? lrupr_pkg::ST_CMP : lrupr_pkg::ST_IDLE;
         end
         lrupr_pkg::ST_CMP: begin
            state_in = lrupr_pkg::ST_SEL;
         end
         lrupr_pkg::ST_SEL: begin
            state_in = lrupr_pkg::ST_UPD;
         end
         lrupr_pkg::ST_UPD: begin
            state_in = lrupr_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrupr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         lrupr_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         lrupr_pkg::ST_CMP: begin
            cmd.cmp = 1'b1;
         end
         lrupr_pkg::ST_SEL: begin
            cmd.sel = 1'b1;
         end
         lrupr_pkg::ST_UPD: begin
            cmd.upd = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

/* rtl/lrupr_dp.sv */
// lrupr_dp: frame table, recency ranks, fault counter, victim search tree
// and result register. Depends on lrupr_pkg.
module lrupr_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  lrupr_pkg::ctrl_cmd_type           cmd,
   input  lrupr_pkg::req_type                req_item,
   input  logic                              csr_we,
   input  logic [lrupr_pkg::CFG_BITS-1:0]    csr_wdata,
   output logic                              rsp_valid,
   output lrupr_pkg::rsp_type                rsp_item
);

   localparam int F  = lrupr_pkg::FRAMES;
   localparam int IB = lrupr_pkg::IDX_BITS;
   localparam int RB = lrupr_pkg::RANK_BITS;
   localparam int PB = lrupr_pkg::PAGE_BITS;
   localparam int CB = lrupr_pkg::CNT_BITS;
   localparam int NG = lrupr_pkg::NUM_GRPS;
   localparam int GS = lrupr_pkg::GRP_SIZE;

   // configuration
   logic [lrupr_pkg::CFG_BITS-1:0] csr_ff;

   // captured item
   logic [PB-1:0] page_ff;
   logic          last_ff;
   logic [F-1:0]  act_mask_ff, act_mask_in;

   // table state
   logic [PB-1:0] frame_page_ff [F];
   logic [PB-1:0] frame_page_in [F];
   logic [F-1:0]  valid_ff, valid_in;
   logic [RB-1:0] rank_ff [F];
   logic [RB-1:0] rank_in [F];
   logic [CB-1:0] count_ff, count_in;

   // lookup results
   logic          hit_ff, hit_in;
   logic [IB-1:0] hit_idx_ff, hit_idx_in;
   logic          empty_ff, empty_in;
   logic [IB-1:0] empty_idx_ff, empty_idx_in;
   logic [IB-1:0] grp_idx_ff [NG];
   logic [IB-1:0] grp_idx_in [NG];
   logic [RB-1:0] grp_rank_ff [NG];
   logic [RB-1:0] grp_rank_in [NG];
   logic [NG-1:0] grp_any_ff, grp_any_in;

   // decision
   logic          fault_ff, fault_in;
   logic [IB-1:0] slot_ff, slot_in;
   logic          evict_ff, evict_in;
   logic [PB-1:0] ev_page_ff, ev_page_in;
   logic          age_all_ff, age_all_in;
   logic [RB-1:0] limit_ff, limit_in;

   // result
   logic                 rsp_valid_ff;
   lrupr_pkg::rsp_type   rsp_ff, rsp_in;

   // active frame mask from the clamped register value
   always_comb begin
      int act;
      act = int'(csr_ff);
      if (act < 1) act = 1;
      if (act > F) act = F;
      for (int j = 0; j < F; j++) begin
         act_mask_in[j] = (j < act);
      end
   end

   // lookup: lowest matching frame, lowest empty frame, per-group oldest
   always_comb begin
      logic          any;
      logic [RB-1:0] best;
      logic [IB-1:0] bidx;
      hit_in       = 1'b0;
      hit_idx_in   = '0;
      empty_in     = 1'b0;
      empty_idx_in = '0;
      for (int j = F - 1; j >= 0; j--) begin
         if (act_mask_ff[j] && valid_ff[j] && frame_page_ff[j] == page_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = IB'(j);
         end
         if (act_mask_ff[j] && !valid_ff[j]) begin
            empty_in     = 1'b1;
            empty_idx_in = IB'(j);
         end
      end
      for (int g = 0; g < NG; g++) begin
         any  = 1'b0;
         best = '0;
         bidx = '0;
         for (int k = 0; k < GS; k++) begin
            if (g * GS + k < F) begin
               if (act_mask_ff[g * GS + k] && (!any || rank_ff[g * GS + k] > best)) begin
                  any  = 1'b1;
                  best = rank_ff[g * GS + k];
                  bidx = IB'(g * GS + k);
               end
            end
         end
         grp_any_in[g]  = any;
         grp_rank_in[g] = best;
         grp_idx_in[g]  = bidx;
      end
   end

   // select: final victim over the group winners, then the slot
   always_comb begin
      logic [RB-1:0] best;
      logic [IB-1:0] victim;
      best   = grp_rank_ff[0];
      victim = grp_idx_ff[0];
      for (int g = 1; g < NG; g++) begin
         if (grp_any_ff[g] && grp_rank_ff[g] > best) begin
            best   = grp_rank_ff[g];
            victim = grp_idx_ff[g];
         end
      end
      fault_in   = !hit_ff;
      evict_in   = !hit_ff && !empty_ff;
      age_all_in = !hit_ff && empty_ff;
      if (hit_ff) begin
         slot_in = hit_idx_ff;
      end else if (empty_ff) begin
         slot_in = empty_idx_ff;
      end else begin
         slot_in = victim;
      end
      limit_in   = rank_ff[slot_in];
      ev_page_in = evict_in ? frame_page_ff[slot_in] : '0;
   end

   // update: age, refresh, fill, count, and clear on the last reference
   always_comb begin
      logic [CB-1:0] cnt;
      for (int j = 0; j < F; j++) begin
         frame_page_in[j] = frame_page_ff[j];
         rank_in[j]       = rank_ff[j];
         if (valid_ff[j] && IB'(j) != slot_ff && rank_ff[j] != lrupr_pkg::RANK_MAX &&
             (age_all_ff || rank_ff[j] < limit_ff)) begin
            rank_in[j] = rank_ff[j] + RB'(1);
         end
      end
      valid_in = valid_ff;
      rank_in[slot_ff] = '0;
      if (fault_ff) begin
         valid_in[slot_ff]      = 1'b1;
         frame_page_in[slot_ff] = page_ff;
      end
      cnt = count_ff;
      if (fault_ff && count_ff != lrupr_pkg::COUNT_MAX) begin
         cnt = count_ff + CB'(1);
      end
      count_in = cnt;

      rsp_in.fault         = fault_ff;
      rsp_in.slot          = slot_ff;
      rsp_in.evicted_valid = evict_ff;
      rsp_in.evicted_page  = ev_page_ff;
      rsp_in.fault_count   = cnt;

      if (last_ff) begin
         valid_in = '0;
         count_in = '0;
         for (int j = 0; j < F; j++) begin
            rank_in[j] = '0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= lrupr_pkg::CFG_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < F; j++) begin
            rank_ff[j] <= '0;
         end
      end else begin
         if (csr_we) begin
            csr_ff <= csr_wdata;
         end
         rsp_valid_ff <= cmd.upd;
         if (cmd.upd) begin
            valid_ff <= valid_in;
            count_ff <= count_in;
            for (int j = 0; j < F; j++) begin
               rank_ff[j] <= rank_in[j];
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff     <= req_item.page;
         last_ff     <= req_item.last_ref;
         act_mask_ff <= act_mask_in;
      end
      if (cmd.cmp) begin
         hit_ff       <= hit_in;
         hit_idx_ff   <= hit_idx_in;
         empty_ff     <= empty_in;
         empty_idx_ff <= empty_idx_in;
         grp_any_ff   <= grp_any_in;
         for (int g = 0; g < NG; g++) begin
            grp_idx_ff[g]  <= grp_idx_in[g];
            grp_rank_ff[g] <= grp_rank_in[g];
         end
      end
      if (cmd.sel) begin
         fault_ff   <= fault_in;
         slot_ff    <= slot_in;
         evict_ff   <= evict_in;
         ev_page_ff <= ev_page_in;
         age_all_ff <= age_all_in;
         limit_ff   <= limit_in;
      end
      if (cmd.upd) begin
         rsp_ff <= rsp_in;
         for (int j = 0; j < F; j++) begin
            frame_page_ff[j] <= frame_page_in[j];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* rtl/lru_page_replacement.sv */
// lru_page_replacement: fully associative page frame table with LRU
// replacement. Joins the lrupr_ctrl sequencer and the lrupr_dp datapath.
// Each accepted item passes through lookup, victim select and table update,
//   then shows its result with rsp_valid high for one cycle.
// Busy while an item is in flight: a new item is accepted only when idle,
//   after the previous item's table update.
// Reset (synchronous): table invalid, ranks and fault count zero,
//   frames_in_use 16; no clearing pass. The receiver cannot stall results.
module lru_page_replacement (
   input  logic                           clock,
   input  logic                           reset,
   // item request
   input  logic                           start,
   output logic                           busy,
   input  lrupr_pkg::req_type             req_item,
   // item result, one cycle strobe
   output logic                           rsp_valid,
   output lrupr_pkg::rsp_type             rsp_item,
   // frames_in_use register
   input  logic                           csr_we,
   input  logic [lrupr_pkg::CFG_BITS-1:0] csr_wdata
);

   lrupr_pkg::ctrl_cmd_type cmd;

   // sequencer: idle -> lookup -> select -> update
   lrupr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // frame table, recency ranks, counter and result register
   lrupr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
